>>> hw/rtl/snc_pkg.sv
// package for the spiral nearest cell search block
// widths, codes and the command/status structs shared by controller, datapath and top
// no dependencies
package snc_pkg;

   localparam int COORD_BITS  = 16;
   localparam int DELTA_BITS  = 16;
   localparam int STEP_BITS   = DELTA_BITS + 1;
   localparam int BUDGET_BITS = 18;
   localparam int CFG_BITS    = 16;
   localparam int DIST_BITS   = 32;
   localparam int SIDE_BITS   = 2;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_SEARCH_BUDGET = 1'b0;

   localparam logic [CFG_BITS-1:0] BUDGET_RESET = CFG_BITS'(400);

   localparam logic MODE_START  = 1'b0;
   localparam logic MODE_ANSWER = 1'b1;

   localparam logic KIND_PROBE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [SIDE_BITS-1:0] SIDE_POS_X = 2'd0;
   localparam logic [SIDE_BITS-1:0] SIDE_POS_Y = 2'd1;
   localparam logic [SIDE_BITS-1:0] SIDE_NEG_X = 2'd2;
   localparam logic [SIDE_BITS-1:0] SIDE_NEG_Y = 2'd3;

   typedef enum logic [2:0] {
      OUT_PROBE_CENTER,
      OUT_PROBE_STEP,
      OUT_DONE_CENTER,
      OUT_DONE_BEST,
      OUT_DONE_FAIL
   } out_sel_type;

   typedef struct packed {
      logic        load_start;
      logic        ring_first;
      logic        ring_next;
      logic        side_next;
      logic        move;
      logic        record;
      logic        out_load;
      out_sel_type out_sel;
   } snc_cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic side_last;
      logic best_found;
      logic budget_le0;
      logic hit;
      logic out_free;
   } snc_stat_type;

endpackage

>>> hw/rtl/snc_if.sv
// valid/ready channel interfaces for the search requests and responses
// depends on snc_pkg
interface snc_req_if
   import snc_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic                         probe_pass;

   modport source (output valid, mode, center_x, center_y, probe_pass, input ready);
   modport sink (input valid, mode, center_x, center_y, probe_pass, output ready);
endinterface

interface snc_rsp_if
   import snc_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic signed [COORD_BITS-1:0] cell_x;
   logic signed [COORD_BITS-1:0] cell_y;
   logic                         success;

   modport source (output valid, result_kind, cell_x, cell_y, success, input ready);
   modport sink (input valid, result_kind, cell_x, cell_y, success, output ready);
endinterface

>>> hw/rtl/snc_datapath.sv
// datapath: ring walk position, incremental squared distance, budget, best cell
// and the response register; driven by snc_ctrl commands. depends on snc_pkg
module snc_datapath
   import snc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  snc_cmd_type                  cmd,
   output snc_stat_type                 stat,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic [CFG_BITS-1:0]          search_budget,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_kind,
   output logic signed [COORD_BITS-1:0] rsp_x,
   output logic signed [COORD_BITS-1:0] rsp_y,
   output logic                         rsp_success
);

   logic [COORD_BITS-1:0]         origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]         origin_y_ff, origin_y_in;
   logic signed [COORD_BITS-1:0]  off_x_ff, off_x_in;
   logic signed [COORD_BITS-1:0]  off_y_ff, off_y_in;
   logic [DIST_BITS-1:0]          dist_ff, dist_in;
   logic [DELTA_BITS-1:0]         delta_ff, delta_in;
   logic [SIDE_BITS-1:0]          side_ff, side_in;
   logic [STEP_BITS-1:0]          steps_ff, steps_in;
   logic signed [BUDGET_BITS-1:0] budget_ff, budget_in;
   logic [DIST_BITS-1:0]          best_dist_ff, best_dist_in;
   logic [COORD_BITS-1:0]         best_x_ff, best_x_in;
   logic [COORD_BITS-1:0]         best_y_ff, best_y_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [COORD_BITS-1:0]         rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]         rsp_y_ff, rsp_y_in;
   logic                          rsp_success_ff, rsp_success_in;

   logic signed [COORD_BITS-1:0]  off_x_move, off_y_move;
   logic [DIST_BITS-1:0]          twice_off;
   logic [DIST_BITS-1:0]          dist_term;
   logic [DIST_BITS-1:0]          dist_move;
   logic [SIDE_BITS-1:0]          side_inc;
   logic [STEP_BITS-1:0]          side_steps;
   logic [DELTA_BITS-1:0]         delta_inc;
   logic [BUDGET_BITS-1:0]        cost_first;
   logic [BUDGET_BITS-1:0]        cost_next;

   // one step along the current side; squared distance follows as d +/- 2*o + 1
   always_comb begin
      off_x_move = off_x_ff;
      off_y_move = off_y_ff;
      twice_off  = '0;
      dist_term  = '0;
      unique case (side_ff)
         SIDE_POS_X: begin
            off_x_move = off_x_ff + COORD_BITS'(1);
            twice_off  = DIST_BITS'({{(DIST_BITS-COORD_BITS){off_x_ff[COORD_BITS-1]}},
                                     off_x_ff} <<< 1);
            dist_term  = twice_off + DIST_BITS'(1);
         end
         SIDE_POS_Y: begin
            off_y_move = off_y_ff + COORD_BITS'(1);
            twice_off  = DIST_BITS'({{(DIST_BITS-COORD_BITS){off_y_ff[COORD_BITS-1]}},
                                     off_y_ff} <<< 1);
            dist_term  = twice_off + DIST_BITS'(1);
         end
         SIDE_NEG_X: begin
            off_x_move = off_x_ff - COORD_BITS'(1);
            twice_off  = DIST_BITS'({{(DIST_BITS-COORD_BITS){off_x_ff[COORD_BITS-1]}},
                                     off_x_ff} <<< 1);
            dist_term  = DIST_BITS'(1) - twice_off;
         end
         default: begin
            off_y_move = off_y_ff - COORD_BITS'(1);
            twice_off  = DIST_BITS'({{(DIST_BITS-COORD_BITS){off_y_ff[COORD_BITS-1]}},
                                     off_y_ff} <<< 1);
            dist_term  = DIST_BITS'(1) - twice_off;
         end
      endcase
      dist_move = dist_ff + dist_term;
   end

   assign side_inc   = side_ff + SIDE_BITS'(1);
   assign side_steps = (side_inc < SIDE_NEG_X) ? {1'b0, delta_ff}
                                               : {1'b0, delta_ff} + STEP_BITS'(1);
   assign delta_inc  = delta_ff + DELTA_BITS'(2);
   assign cost_first = {delta_ff, 2'b10};
   assign cost_next  = {delta_inc, 2'b10};

   assign stat.steps_zero = (steps_ff == '0);
   assign stat.side_last  = (side_ff == SIDE_NEG_Y);
   assign stat.best_found = (best_dist_ff != '0);
   assign stat.budget_le0 = budget_ff[BUDGET_BITS-1] || (budget_ff == '0);
   assign stat.hit        = (best_dist_ff == '0) || (dist_move < best_dist_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      dist_in      = dist_ff;
      delta_in     = delta_ff;
      side_in      = side_ff;
      steps_in     = steps_ff;
      budget_in    = budget_ff;
      best_dist_in = best_dist_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;

      if (cmd.load_start) begin
         origin_x_in  = center_x;
         origin_y_in  = center_y;
         off_x_in     = '0;
         off_y_in     = '0;
         dist_in      = '0;
         delta_in     = DELTA_BITS'(1);
         side_in      = SIDE_POS_X;
         steps_in     = '0;
         budget_in    = BUDGET_BITS'(search_budget);
         best_dist_in = '0;
         best_x_in    = '0;
         best_y_in    = '0;
      end
      if (cmd.ring_first) begin
         budget_in = budget_ff - signed'(cost_first);
         side_in   = SIDE_POS_X;
         steps_in  = {1'b0, delta_ff};
      end
      if (cmd.ring_next) begin
         delta_in  = delta_inc;
         budget_in = budget_ff - signed'(cost_next);
         side_in   = SIDE_POS_X;
         steps_in  = {1'b0, delta_inc};
      end
      if (cmd.side_next) begin
         side_in  = side_inc;
         steps_in = side_steps;
      end
      if (cmd.move) begin
         off_x_in = off_x_move;
         off_y_in = off_y_move;
         dist_in  = dist_move;
         steps_in = steps_ff - STEP_BITS'(1);
      end
      if (cmd.record) begin
         best_dist_in = dist_ff;
         best_x_in    = origin_x_ff + off_x_ff;
         best_y_in    = origin_y_ff + off_y_ff;
      end
   end

   always_comb begin
      rsp_kind_in    = rsp_kind_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_success_in = rsp_success_ff;
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            OUT_PROBE_CENTER: begin
               rsp_kind_in    = KIND_PROBE;
               rsp_x_in       = center_x;
               rsp_y_in       = center_y;
               rsp_success_in = 1'b0;
            end
            OUT_PROBE_STEP: begin
               rsp_kind_in    = KIND_PROBE;
               rsp_x_in       = origin_x_ff + off_x_move;
               rsp_y_in       = origin_y_ff + off_y_move;
               rsp_success_in = 1'b0;
            end
            OUT_DONE_CENTER: begin
               rsp_kind_in    = KIND_DONE;
               rsp_x_in       = origin_x_ff;
               rsp_y_in       = origin_y_ff;
               rsp_success_in = 1'b1;
            end
            OUT_DONE_BEST: begin
               rsp_kind_in    = KIND_DONE;
               rsp_x_in       = best_x_ff;
               rsp_y_in       = best_y_ff;
               rsp_success_in = 1'b1;
            end
            default: begin
               rsp_kind_in    = KIND_DONE;
               rsp_x_in       = '0;
               rsp_y_in       = '0;
               rsp_success_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      off_x_ff       <= off_x_in;
      off_y_ff       <= off_y_in;
      dist_ff        <= dist_in;
      delta_ff       <= delta_in;
      side_ff        <= side_in;
      steps_ff       <= steps_in;
      budget_ff      <= budget_in;
      best_dist_ff   <= best_dist_in;
      best_x_ff      <= best_x_in;
      best_y_ff      <= best_y_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_success_ff <= rsp_success_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_x       = rsp_x_ff;
   assign rsp_y       = rsp_y_ff;
   assign rsp_success = rsp_success_ff;

endmodule

>>> hw/rtl/snc_ctrl.sv
// controller FSM: request decode and the ring walk sequencer, at most one cell per cycle
// while output is free; depends on snc_pkg; drives snc_datapath through snc_cmd_type
module snc_ctrl
   import snc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_mode,
   input  logic         req_pass,
   output logic         req_ready,
   input  snc_stat_type stat,
   output snc_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_CENTER,
      ST_WAIT_RING,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff != ST_WALK) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd            = '0;
      cmd.out_sel    = OUT_DONE_FAIL;
      state_in       = state_ff;

      if (accept && (req_mode == MODE_START)) begin
         cmd.load_start = 1'b1;
         cmd.out_load   = 1'b1;
         cmd.out_sel    = OUT_PROBE_CENTER;
         state_in       = ST_WAIT_CENTER;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               // answers with no search running are dropped
               state_in = ST_IDLE;
            end
            ST_WAIT_CENTER: begin
               if (accept) begin
                  priority if (req_pass) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_DONE_CENTER;
                     state_in     = ST_IDLE;
                  end else if (stat.budget_le0) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_DONE_FAIL;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.ring_first = 1'b1;
                     state_in       = ST_WALK;
                  end
               end
            end
            ST_WAIT_RING: begin
               if (accept) begin
                  cmd.record = req_pass;
                  state_in   = ST_WALK;
               end
            end
            default: begin
               if (stat.out_free) begin
                  if (stat.steps_zero) begin
                     priority if (!stat.side_last) begin
                        cmd.side_next = 1'b1;
                     end else if (stat.best_found) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_DONE_BEST;
                        state_in     = ST_IDLE;
                     end else if (stat.budget_le0) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_DONE_FAIL;
                        state_in     = ST_IDLE;
                     end else begin
                        cmd.ring_next = 1'b1;
                     end
                  end else begin
                     cmd.move = 1'b1;
                     // cells no closer than the best pass are skipped silently
                     if (stat.hit) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_PROBE_STEP;
                        state_in     = ST_WAIT_RING;
                     end
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/spiral_nearest_cell_search.sv
// Spiral nearest cell search. A start transfer (mode 0) gives a center cell and the
// block answers in the next cycle with a probe for that cell. Each answer transfer
// (mode 1) carries pass/fail for the last probe; the walk sequencer then steps
// outward over square rings, one cell or one side/ring turn per clock while the
// response output is free, skipping cells no closer than the best pass so far,
// until it emits the next probe or the finished result. The search_budget register
// (byte address 0, reset 400) limits the rings; each ring costs 4*delta+2.
// Coordinates wrap at 16 bits. Write the register only while no search is in
// flight. Answers with no search running are dropped.
module spiral_nearest_cell_search
   import snc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   snc_req_if.sink                  req_bus,
   snc_rsp_if.source                rsp_bus,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [CFG_BITS-1:0] search_budget_ff, search_budget_in;
   logic                csr_write;
   logic                budget_hit;
   snc_cmd_type         cmd;
   snc_stat_type        stat;

   assign csr_pready = 1'b1;
   assign budget_hit = (csr_paddr[2] == CSR_IDX_SEARCH_BUDGET);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign search_budget_in = (csr_write && budget_hit) ? csr_pwdata[CFG_BITS-1:0]
                                                       : search_budget_ff;
   assign csr_prdata = budget_hit ? CSR_DATA_BITS'(search_budget_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_budget_ff <= BUDGET_RESET;
      end else begin
         search_budget_ff <= search_budget_in;
      end
   end

   snc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_pass  (req_bus.probe_pass),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   snc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .center_x      (req_bus.center_x),
      .center_y      (req_bus.center_y),
      .search_budget (search_budget_ff),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_kind      (rsp_bus.result_kind),
      .rsp_x         (rsp_bus.cell_x),
      .rsp_y         (rsp_bus.cell_y),
      .rsp_success   (rsp_bus.success)
   );

endmodule
